// ===== rtl/core/thd_pkg.sv =====
// Shared types and constants of the harmonic THD calculation unit.
`default_nettype none

package thd_pkg;

    localparam int MAG_W      = 15;
    localparam int PCT_W      = 7;
    localparam int THD_W      = 32;
    localparam int PCT_SCALE  = 100;
    localparam int FULL_SCALE = 32767;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;

    typedef enum logic [1:0] {
        KIND_SKIP,
        KIND_FUND,
        KIND_HARM,
        KIND_LAST
    } thd_kind_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [PCT_W-1:0] pct;
        thd_kind_t        kind;
    } thd_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } thd_q_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } thd_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/harmonic_thd_calc_unit.sv =====
// Top level of the harmonic THD calculation unit.
// An ordinary bin word passes through the queue and then the result register.
// The last bin also runs an iterative root and divide: 2-bit root, 1-bit divide.
// Throughput: one word per cycle through a 4-word queue when nothing stalls, but the back end stops popping
// from a last bin until its frame result is out, and while a result word is stalled.
// Reset (rst_n low, asynchronous): frame position, fundamental and sum cleared, queue empty.
`default_nettype none

module harmonic_thd_calc_unit
    import thd_pkg::*;
#(
    parameter int NUM_POINTS = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // bin word channel
    input  wire logic             bin_valid,
    output logic                  bin_stall,
    input  wire logic [MAG_W-1:0] bin_magnitude,
    // result word channel
    output logic                  res_valid,
    input  wire logic             res_stall,
    output logic [PCT_W-1:0]      bin_percent,
    output logic                  frame_done,
    output logic [THD_W-1:0]      thd_percent_q8
);

    // Front end tags each bin (skip, fundamental, harmonic, last) and
    // scales it to percent; the back end does everything that needs
    // frame state, so a long root/divide never blocks the input side
    // until the queue fills.
    thd_item_t   push_item;
    thd_item_t   pop_item;
    thd_q_stat_t q_stat;
    logic        push;
    logic        pop;

    thd_front #(
        .NUM_POINTS (NUM_POINTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .bin_valid     (bin_valid),
        .bin_stall     (bin_stall),
        .bin_magnitude (bin_magnitude),
        .q_stat        (q_stat),
        .push          (push),
        .item          (push_item)
    );

    thd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (push_item),
        .pop     (pop),
        .rd_item (pop_item),
        .q_stat  (q_stat)
    );

    // Back end: sum of squares, then sqrt(sum << 16) * 100 / fundamental
    // on the last bin, saturated to 32 bits.
    thd_back #(
        .NUM_POINTS (NUM_POINTS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (pop_item),
        .q_stat         (q_stat),
        .pop            (pop),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .bin_percent    (bin_percent),
        .frame_done     (frame_done),
        .thd_percent_q8 (thd_percent_q8)
    );

endmodule

`default_nettype wire

// ===== rtl/core/thd_front.sv =====
// Front end: takes bin words, scales to percent, tags each bin by its frame position.
`default_nettype none

module thd_front
    import thd_pkg::*;
#(
    parameter int NUM_POINTS = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             bin_valid,
    output logic                  bin_stall,
    input  wire logic [MAG_W-1:0] bin_magnitude,
    input  wire thd_q_stat_t      q_stat,
    output logic                  push,
    output thd_item_t             item
);

    localparam int IDX_W = $clog2(NUM_POINTS);

    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [MAG_W+PCT_W-1:0] scaled;
    logic [PCT_W-1:0]     q0;
    logic [MAG_W:0]       rem;
    logic                 last;

    assign bin_stall = q_stat.full;
    assign push      = bin_valid && !q_stat.full;
    assign last      = (idx_reg == IDX_W'(NUM_POINTS - 1));

    // x/32767: x>>15 is at most one short, the remainder tells which
    always_comb
    begin
        scaled = (MAG_W+PCT_W)'(bin_magnitude) * (MAG_W+PCT_W)'(PCT_SCALE);
        q0     = scaled[MAG_W+PCT_W-1:MAG_W];
        rem    = {1'b0, scaled[MAG_W-1:0]} + (MAG_W+1)'(q0);
        item.mag = bin_magnitude;
        item.pct = (rem >= (MAG_W+1)'(FULL_SCALE)) ? q0 + 1'b1 : q0;
        priority if (last)
        begin
            item.kind = KIND_LAST;
        end
        else if (idx_reg == IDX_W'(1))
        begin
            item.kind = KIND_FUND;
        end
        else if (idx_reg == '0)
        begin
            item.kind = KIND_SKIP;
        end
        else
        begin
            item.kind = KIND_HARM;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (push)
        begin
            idx_next = last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/thd_queue.sv =====
// Small word queue between front end and back end.
`default_nettype none

module thd_queue
    import thd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire thd_item_t wr_item,
    input  wire logic      pop,
    output thd_item_t      rd_item,
    output thd_q_stat_t    q_stat
);

    thd_item_t             mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]    wr_ptr_reg;
    logic [Q_PTR_W-1:0]    wr_ptr_next;
    logic [Q_PTR_W-1:0]    rd_ptr_reg;
    logic [Q_PTR_W-1:0]    rd_ptr_next;
    logic [Q_PTR_W:0]      count_reg;
    logic [Q_PTR_W:0]      count_next;

    assign q_stat.full  = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign rd_item      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/thd_back.sv =====
// Back end: harmonic accumulation, iterative root and divide, result register.
`default_nettype none

module thd_back
    import thd_pkg::*;
#(
    parameter int NUM_POINTS = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire thd_item_t        item,
    input  wire thd_q_stat_t      q_stat,
    output logic                  pop,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output logic [PCT_W-1:0]      bin_percent,
    output logic                  frame_done,
    output logic [THD_W-1:0]      thd_percent_q8
);

    localparam int SUM_W  = 2 * MAG_W + $clog2(NUM_POINTS);
    localparam int RAD_W  = SUM_W + 16 + (SUM_W % 2);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int N_W    = ROOT_W + 7;
    localparam int CNT_W  = $clog2(N_W);

    thd_state_t          state_reg, state_next;
    logic [MAG_W-1:0]    fund_reg, fund_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [N_W-1:0]      num_reg, num_next;
    logic [MAG_W-1:0]    drem_reg, drem_next;
    logic [MAG_W-1:0]    div_reg, div_next;
    logic [CNT_W-1:0]    step_reg, step_next;
    logic [PCT_W-1:0]    hold_reg, hold_next;
    logic                out_valid_reg, out_valid_next;
    logic [PCT_W-1:0]    out_pct_reg, out_pct_next;
    logic                out_done_reg, out_done_next;
    logic [THD_W-1:0]    out_thd_reg, out_thd_next;

    logic                out_free;
    logic [2*MAG_W-1:0]  sq;
    logic [SUM_W-1:0]    sum_add;
    logic [REM_W-1:0]    rem_sh;
    logic [REM_W-1:0]    trial;
    logic [MAG_W:0]      dtry;
    logic                dge;
    logic [63:0]         quot;

    assign out_free       = !out_valid_reg || !res_stall;
    assign pop            = (state_reg == ST_IDLE) && !q_stat.empty && out_free;
    assign res_valid      = out_valid_reg;
    assign bin_percent    = out_pct_reg;
    assign frame_done     = out_done_reg;
    assign thd_percent_q8 = out_thd_reg;

    assign sq      = (2*MAG_W)'(item.mag) * (2*MAG_W)'(item.mag);
    assign sum_add = sum_reg + SUM_W'(sq);
    assign rem_sh  = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial   = REM_W'({root_reg, 2'b01});
    assign dtry    = {drem_reg, num_reg[N_W-1]};
    assign dge     = (dtry >= {1'b0, div_reg});
    assign quot    = 64'(num_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop && (item.kind == KIND_LAST))
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (step_reg == CNT_W'(ROOT_W - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == CNT_W'(N_W - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and result register
    always_comb
    begin
        fund_next      = fund_reg;
        sum_next       = sum_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        num_next       = num_reg;
        drem_next      = drem_reg;
        div_next       = div_reg;
        step_next      = step_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg && res_stall;
        out_pct_next   = out_pct_reg;
        out_done_next  = out_done_reg;
        out_thd_next   = out_thd_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    out_pct_next  = item.pct;
                    out_done_next = 1'b0;
                    out_thd_next  = '0;
                    unique case (item.kind)
                        KIND_SKIP:
                        begin
                            out_valid_next = 1'b1;
                        end
                        KIND_FUND:
                        begin
                            fund_next      = item.mag;
                            out_valid_next = 1'b1;
                        end
                        KIND_HARM:
                        begin
                            sum_next       = sum_add;
                            out_valid_next = 1'b1;
                        end
                        KIND_LAST:
                        begin
                            rad_next  = RAD_W'(sum_add) << 16;
                            rem_next  = '0;
                            root_next = '0;
                            step_next = '0;
                            div_next  = fund_reg;
                            hold_next = item.pct;
                            fund_next = '0;
                            sum_next  = '0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SQRT:
            begin
                // two radicand bits per step
                rad_next  = rad_reg << 2;
                step_next = step_reg + 1'b1;
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            ST_MUL:
            begin
                num_next  = N_W'(root_reg) * N_W'(PCT_SCALE);
                drem_next = '0;
                step_next = '0;
            end
            ST_DIV:
            begin
                // restoring divide, quotient bits shift in behind the dividend
                step_next = step_reg + 1'b1;
                num_next  = {num_reg[N_W-2:0], dge};
                drem_next = dge ? MAG_W'(dtry - {1'b0, div_reg}) : dtry[MAG_W-1:0];
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pct_next   = hold_reg;
                    out_done_next  = 1'b1;
                    priority if (div_reg == '0)
                    begin
                        out_thd_next = '0;
                    end
                    else if (|quot[63:THD_W])
                    begin
                        out_thd_next = '1;
                    end
                    else
                    begin
                        out_thd_next = quot[THD_W-1:0];
                    end
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && res_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fund_reg      <= '0;
            sum_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fund_reg      <= fund_next;
            sum_reg       <= sum_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        num_reg      <= num_next;
        drem_reg     <= drem_next;
        div_reg      <= div_next;
        hold_reg     <= hold_next;
        out_pct_reg  <= out_pct_next;
        out_done_reg <= out_done_next;
        out_thd_reg  <= out_thd_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/thd_checker.sv =====
// Port-level checker for the harmonic THD calculation unit, with its bind.
`default_nettype none

module thd_checker
    import thd_pkg::*;
#(
    parameter int NUM_POINTS = 64
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             bin_valid,
    input wire logic             bin_stall,
    input wire logic [MAG_W-1:0] bin_magnitude,
    input wire logic             res_valid,
    input wire logic             res_stall,
    input wire logic [PCT_W-1:0] bin_percent,
    input wire logic             frame_done,
    input wire logic [THD_W-1:0] thd_percent_q8
);

    localparam int IDX_W = $clog2(NUM_POINTS);

    logic [IDX_W-1:0] out_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_idx_reg <= '0;
        end
        else if (res_valid && !res_stall)
        begin
            out_idx_reg <= (out_idx_reg == IDX_W'(NUM_POINTS - 1)) ? '0 : out_idx_reg + 1'b1;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(bin_percent)
            && $stable(frame_done) && $stable(thd_percent_q8))
        else $error("result word changed while stalled");

    a_bin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid && bin_stall |=> bin_valid && $stable(bin_magnitude))
        else $error("bin word changed while stalled");

    a_frame_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (frame_done == (out_idx_reg == IDX_W'(NUM_POINTS - 1))))
        else $error("frame_done off the last bin of a frame");

    a_thd_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !frame_done |-> (thd_percent_q8 == '0) && (bin_percent <= PCT_W'(PCT_SCALE)))
        else $error("bad result word outside frame end");

endmodule

bind harmonic_thd_calc_unit thd_checker #(
    .NUM_POINTS (NUM_POINTS)
) u_thd_checker (.*);

`default_nettype wire
